FILE: rtl/float_remainder_fmod_assert.svh
// Assertion macros for the floating remainder block.
`ifndef FLOAT_REMAINDER_FMOD_ASSERT_SVH
`define FLOAT_REMAINDER_FMOD_ASSERT_SVH
// a implies b in the same cycle
`define FRM_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// a implies b in the next cycle
`define FRM_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

FILE: rtl/frm_pkg.sv
// Shared types and constants for the floating remainder block.
package frm_pkg;
    localparam int unsigned MantW = 54;
    localparam int unsigned ExpW  = 13;
    localparam logic [63:0] Qnan64 = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] Qnan32 = 64'h0000_0000_7FC0_0000;

    typedef struct packed {
        logic [63:0] x_bits;
        logic [63:0] y_bits;
    } t_in;

    typedef struct packed {
        logic [63:0] rem_bits;
        logic        invalid;
    } t_out;

    // datapath step commands from sequencer
    typedef enum logic [2:0] {
        OP_HOLD, OP_NORM_X, OP_NORM_Y, OP_DIV, OP_FINAL, OP_RENORM
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_ctl;

    typedef struct packed {
        logic x_norm;     // mx has hidden bit
        logic y_norm;
        logic n_zero;     // exponent difference done
        logic m_eq;       // mx == my
        logic m_zero;
        logic r_norm;     // result has hidden bit
    } t_sts;
endpackage

FILE: rtl/frm_if.sv
// Valid/ready channel interface carrying one payload type.
interface frm_in_if (input logic i_clk);
    logic            valid;
    logic            ready;
    frm_pkg::t_in    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface frm_out_if (input logic i_clk);
    logic            valid;
    logic            ready;
    frm_pkg::t_out   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface frm_cfg_if (input logic i_clk);
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/frm_dp.sv
// Shared shift-subtract datapath: significand registers and exponent counters.
module frm_dp (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_sp,
    input  logic [62:0]                 i_ax,
    input  logic [62:0]                 i_ay,
    input  frm_pkg::t_ctl               i_ctl,
    output frm_pkg::t_sts               o_sts,
    output logic [frm_pkg::MantW-1:0]   o_mx,
    output logic signed [frm_pkg::ExpW-1:0] o_ey
);
    logic [frm_pkg::MantW-1:0] r_mx, r_my, n_mx, n_my, w_hid;
    logic signed [frm_pkg::ExpW-1:0] r_ex, r_ey, n_ex, n_ey;
    logic [frm_pkg::ExpW-1:0] w_ex0, w_ey0;
    logic [frm_pkg::MantW-1:0] w_fx, w_fy;
    logic w_ge;

    always_comb begin
        if (i_sp) begin
            w_hid = frm_pkg::MantW'(1) << 23;
            w_ex0 = frm_pkg::ExpW'(i_ax[30:23]);
            w_ey0 = frm_pkg::ExpW'(i_ay[30:23]);
            w_fx  = frm_pkg::MantW'(i_ax[22:0]);
            w_fy  = frm_pkg::MantW'(i_ay[22:0]);
        end else begin
            w_hid = frm_pkg::MantW'(1) << 52;
            w_ex0 = frm_pkg::ExpW'(i_ax[62:52]);
            w_ey0 = frm_pkg::ExpW'(i_ay[62:52]);
            w_fx  = frm_pkg::MantW'(i_ax[51:0]);
            w_fy  = frm_pkg::MantW'(i_ay[51:0]);
        end
    end

    assign w_ge = r_mx >= r_my;

    always_comb begin
        n_mx = r_mx;
        n_my = r_my;
        n_ex = r_ex;
        n_ey = r_ey;
        if (i_load) begin
            n_mx = (w_ex0 == '0) ? w_fx : (w_fx | w_hid);
            n_my = (w_ey0 == '0) ? w_fy : (w_fy | w_hid);
            n_ex = (w_ex0 == '0) ? frm_pkg::ExpW'(1) : w_ex0;
            n_ey = (w_ey0 == '0) ? frm_pkg::ExpW'(1) : w_ey0;
        end else begin
            case (i_ctl.op)
                frm_pkg::OP_NORM_X: begin
                    n_mx = r_mx << 1;
                    n_ex = r_ex - 1'b1;
                end
                frm_pkg::OP_NORM_Y: begin
                    n_my = r_my << 1;
                    n_ey = r_ey - 1'b1;
                end
                frm_pkg::OP_DIV: begin
                    n_mx = (w_ge ? (r_mx - r_my) : r_mx) << 1;
                    n_ex = r_ex - 1'b1;
                end
                frm_pkg::OP_FINAL: n_mx = w_ge ? (r_mx - r_my) : r_mx;
                frm_pkg::OP_RENORM: begin
                    n_mx = r_mx << 1;
                    n_ey = r_ey - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx <= n_mx;
        r_my <= n_my;
        r_ex <= n_ex;
        r_ey <= n_ey;
    end

    assign o_sts.x_norm = (r_mx & w_hid) != '0;
    assign o_sts.y_norm = (r_my & w_hid) != '0;
    assign o_sts.n_zero = r_ex == r_ey;
    assign o_sts.m_eq   = r_mx == r_my;
    assign o_sts.m_zero = r_mx == '0;
    assign o_sts.r_norm = (r_mx & w_hid) != '0;
    assign o_mx = r_mx;
    assign o_ey = r_ey;
endmodule

FILE: rtl/float_remainder_fmod.sv
// Top level of the iterative floating remainder (fmod) block.
// fmod(x,y) for binary64, or binary32 in the low 32 bits when the mode
// register is 1. One beat in, one beat out, one operation at a time. Special
// cases (invalid operation, |x|<=|y|) present their result the cycle after the
// input beat. Otherwise, after the load edge, the sequencer steps through:
// subnormal normalization of x and then y (one left shift per step until the
// hidden bit is set), one shift-subtract step per bit of exponent difference,
// a final subtract, renormalization (one left shift per step until the hidden
// bit is set or the remainder is zero), then a pack step, and then the result
// beat is presented. The shared compare/subtract unit in frm_dp sets the rate.
// invalid flags y zero, x inf/NaN or y NaN, with a canonical quiet NaN result.
// Mode writes are accepted only while idle.
module float_remainder_fmod (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frm_cfg_if.sink    cfg,
    frm_in_if.sink     in_ch,
    frm_out_if.source  out_ch
);
    `include "float_remainder_fmod_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_NX, S_NY, S_DIV, S_FIN, S_REN, S_PACK, S_OUT
    } t_state;

    t_state r_state;
    logic   r_sp;
    logic   r_sign;
    frm_pkg::t_out r_out;
    frm_pkg::t_ctl w_ctl;
    frm_pkg::t_sts w_sts;
    logic [frm_pkg::MantW-1:0] w_mx;
    logic signed [frm_pkg::ExpW-1:0] w_ey;
    logic w_load;

    // operand unpack of the incoming beat
    logic [62:0] w_ax, w_ay, w_inf;
    logic        w_sx;
    logic [63:0] w_x;
    always_comb begin
        if (r_sp) begin
            w_ax  = 63'(in_ch.data.x_bits[30:0]);
            w_ay  = 63'(in_ch.data.y_bits[30:0]);
            w_sx  = in_ch.data.x_bits[31];
            w_x   = {32'd0, in_ch.data.x_bits[31:0]};
            w_inf = 63'h7F80_0000;
        end else begin
            w_ax  = in_ch.data.x_bits[62:0];
            w_ay  = in_ch.data.y_bits[62:0];
            w_sx  = in_ch.data.x_bits[63];
            w_x   = in_ch.data.x_bits;
            w_inf = 63'h7FF0_0000_0000_0000;
        end
    end

    assign w_load = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);
    assign cfg.ready   = (r_state == S_IDLE);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.data  = r_out;

    // a step is issued only while its loop condition still calls for it
    always_comb begin
        case (r_state)
            S_NX:    w_ctl.op = w_sts.x_norm ? frm_pkg::OP_HOLD : frm_pkg::OP_NORM_X;
            S_NY:    w_ctl.op = w_sts.y_norm ? frm_pkg::OP_HOLD : frm_pkg::OP_NORM_Y;
            S_DIV:   w_ctl.op = w_sts.n_zero ? frm_pkg::OP_HOLD : frm_pkg::OP_DIV;
            S_FIN:   w_ctl.op = frm_pkg::OP_FINAL;
            S_REN:   w_ctl.op = (w_sts.m_zero || w_sts.r_norm) ? frm_pkg::OP_HOLD
                                                               : frm_pkg::OP_RENORM;
            default: w_ctl.op = frm_pkg::OP_HOLD;
        endcase
    end

    frm_dp u_dp (
        .i_clk (i_clk),
        .i_load(w_load),
        .i_sp  (r_sp),
        .i_ax  (w_ax),
        .i_ay  (w_ay),
        .i_ctl (w_ctl),
        .o_sts (w_sts),
        .o_mx  (w_mx),
        .o_ey  (w_ey)
    );

    // pack: normal when ey >= 1, else shift right by 1-ey (flushes to zero at 54 or more)
    logic [63:0] w_zero, w_pack;
    logic [frm_pkg::ExpW-1:0] w_sh;
    logic [frm_pkg::MantW-1:0] w_sub;
    always_comb begin
        w_zero = r_sp ? {32'd0, r_sign, 31'd0} : {r_sign, 63'd0};
        w_sh   = frm_pkg::ExpW'(1) - frm_pkg::ExpW'(w_ey);
        w_sub  = (w_sh >= frm_pkg::ExpW'(frm_pkg::MantW)) ? '0 : (w_mx >> w_sh);
        if (w_ey >= 1) begin
            if (r_sp) w_pack = w_zero | {33'd0, w_ey[7:0], w_mx[22:0]};
            else      w_pack = w_zero | {1'b0, w_ey[10:0], w_mx[51:0]};
        end else begin
            w_pack = w_zero | 64'(w_sub);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (cfg.valid) r_sp <= cfg.data;
                    if (w_load) begin
                        r_sign <= w_sx;
                        if (w_ay == '0 || w_ax >= w_inf || w_ay > w_inf) begin
                            r_out.rem_bits <= r_sp ? frm_pkg::Qnan32 : frm_pkg::Qnan64;
                            r_out.invalid  <= 1'b1;
                            r_state <= S_OUT;
                        end else if (w_ax < w_ay) begin
                            r_out.rem_bits <= w_x;
                            r_out.invalid  <= 1'b0;
                            r_state <= S_OUT;
                        end else if (w_ax == w_ay) begin
                            r_out.rem_bits <= r_sp ? {32'd0, w_sx, 31'd0} : {w_sx, 63'd0};
                            r_out.invalid  <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_NX;
                        end
                    end
                end
                S_NX: if (w_sts.x_norm) r_state <= S_NY;
                S_NY: if (w_sts.y_norm) r_state <= S_DIV;
                S_DIV: begin
                    if (w_sts.n_zero) begin
                        r_state <= S_FIN;
                    end else if (w_sts.m_eq) begin
                        r_out.rem_bits <= w_zero;
                        r_out.invalid  <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_FIN: r_state <= S_REN;
                S_REN: begin
                    if (w_sts.m_zero) begin
                        r_out.rem_bits <= w_zero;
                        r_out.invalid  <= 1'b0;
                        r_state <= S_OUT;
                    end else if (w_sts.r_norm) begin
                        r_state <= S_PACK;
                    end
                end
                S_PACK: begin
                    r_out.rem_bits <= w_pack;
                    r_out.invalid  <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: if (out_ch.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no new beat while a result is pending
    `FRM_ASSERT_IMP(a_busy_no_accept, r_state != S_IDLE, !in_ch.ready)
    // a stalled result holds its payload
    `FRM_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, $stable(r_out))
    // binary32 results never set upper bits
    `FRM_ASSERT_IMP(a_sp_upper, out_ch.valid && r_sp, r_out.rem_bits[63:32] == 32'd0)
endmodule
